### src/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, codes and types for the interpolator and its arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   localparam int DEFAULT_MAX_POINTS  = 16;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int CSR_WIDTH    = 5;
   localparam int INDEX_WIDTH  = 4;
   localparam int REGION_WIDTH = 2;

   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 5'd1;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [REGION_WIDTH-1:0] {
      REGION_INTERP = 2'd0,
      REGION_FIRST  = 2'd1,
      REGION_LAST   = 2'd2
   } region_type;

   // status of the multiply/divide unit as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mdu_status_type;

endpackage : pli_pkg

`default_nettype wire

### src/pli_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : pli_ram

`default_nettype wire

### src/pli_muldiv.sv
// ----------------------------------------------------------------------------
// Shared multiply/divide unit
// Radix-2 shift-add multiply followed by restoring divide, both on one adder.
// Computes floor(mag * mplr / den), given mplr <= den so the quotient fits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_muldiv #(
   parameter int OP_WIDTH = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [OP_WIDTH-1:0]          mag,
   input  logic [OP_WIDTH-1:0]          mplr,
   input  logic [OP_WIDTH-1:0]          den,
   output logic [OP_WIDTH-1:0]          quotient,
   output pli_pkg::mdu_status_type      status
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(OP_WIDTH);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL,
      PH_DIV
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [OP_WIDTH-1:0]  hi_ff, hi_in;
   logic [OP_WIDTH-1:0]  lo_ff, lo_in;
   logic [OP_WIDTH-1:0]  mag_ff, mag_in;
   logic [OP_WIDTH-1:0]  den_ff, den_in;
   logic                 done_ff, done_in;

   // shared adder
   logic [OP_WIDTH:0]    a_op;
   logic [OP_WIDTH:0]    b_op;
   logic                 sub;
   logic [OP_WIDTH+1:0]  sum;
   logic                 ge;

   always_comb begin
      a_op = '0;
      b_op = '0;
      sub  = 1'b0;
      case (phase_ff)
         PH_MUL: begin
            a_op = {1'b0, hi_ff};
            b_op = lo_ff[0] ? {1'b0, mag_ff} : '0;
         end
         PH_DIV: begin
            a_op = {hi_ff, lo_ff[OP_WIDTH-1]};
            b_op = {1'b0, den_ff};
            sub  = 1'b1;
         end
         default: begin
            sub = 1'b0;
         end
      endcase
      sum = {1'b0, a_op} + (sub ? ~{1'b0, b_op} : {1'b0, b_op}) + (OP_WIDTH+2)'(sub);
      ge  = ~sum[OP_WIDTH+1];
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               hi_in    = '0;
               lo_in    = mplr;
               mag_in   = mag;
               den_in   = den;
               cnt_in   = CNT_W'(OP_WIDTH - 1);
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            // shift the partial product right one place
            hi_in  = sum[OP_WIDTH:1];
            lo_in  = {sum[0], lo_ff[OP_WIDTH-1:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(OP_WIDTH - 1);
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            // high half is already below den, so one pass per quotient bit
            hi_in  = ge ? sum[OP_WIDTH-1:0] : a_op[OP_WIDTH-1:0];
            lo_in  = {lo_ff[OP_WIDTH-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   assign quotient    = lo_ff;
   assign status.busy = (phase_ff != PH_IDLE);
   assign status.done = done_ff;

endmodule : pli_muldiv

`default_nettype wire

### src/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with linear search and interpolation in signed Q16.16.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  action, point_index, point_x/y, query_x
//   rsp      out  rsp_valid/rsp_stall  result_y, region, segment_index
//   csr      in   csr_wr_en            points_in_use
//
// A write item updates the table RAM at acceptance if point_index < MAX_POINTS.
// A query runs from its transfer through a linear search of the entries in use,
// VALUE_WIDTH+1 multiply and VALUE_WIDTH+1 divide steps on the single shared
// adder, and the acceptance, setup, start, completion and delivery steps.
// Clamped queries skip the arithmetic. req_stall is high while a query is in
// progress; a finished result waits in the output register while the next
// item is taken, and a result that meets a still-stalled output register
// holds in delivery.
// Reset is synchronous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator_unit #(
   parameter int MAX_POINTS  = pli_pkg::DEFAULT_MAX_POINTS,
   parameter int VALUE_WIDTH = pli_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [pli_pkg::INDEX_WIDTH-1:0]     req_point_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_point_x,
   input  logic signed [VALUE_WIDTH-1:0]       req_point_y,
   input  logic signed [VALUE_WIDTH-1:0]       req_query_x,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]       rsp_result_y,
   output logic [pli_pkg::REGION_WIDTH-1:0]    rsp_region,
   output logic [pli_pkg::INDEX_WIDTH-1:0]     rsp_segment_index,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [pli_pkg::CSR_WIDTH-1:0]       csr_wr_data
);
   import pli_pkg::*;

   localparam int W      = VALUE_WIDTH;
   localparam int M      = VALUE_WIDTH + 1;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int NW     = ADDR_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SETUP,
      ST_START,
      ST_WAIT,
      ST_DELIVER
   } state_type;

   state_type                state_ff, state_in;
   logic [CSR_WIDTH-1:0]     csr_ff, csr_in;
   logic signed [W-1:0]      q_ff, q_in;
   logic [NW-1:0]            n_ff, n_in;
   logic [ADDR_W-1:0]        cmp_ff, cmp_in;
   logic signed [W-1:0]      lo_x_ff, lo_x_in;
   logic signed [W-1:0]      lo_y_ff, lo_y_in;
   logic signed [W-1:0]      hi_x_ff, hi_x_in;
   logic signed [W-1:0]      hi_y_ff, hi_y_in;
   logic [M-1:0]             dy_ff, dy_in;
   logic [M-1:0]             dxq_ff, dxq_in;
   logic [M-1:0]             den_ff, den_in;
   logic [W-1:0]             res_ff, res_in;
   region_type               region_ff, region_in;
   logic [ADDR_W-1:0]        seg_ff, seg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]             rsp_y_ff, rsp_y_in;
   region_type               rsp_region_ff, rsp_region_in;
   logic [INDEX_WIDTH-1:0]   rsp_seg_ff, rsp_seg_in;

   // table RAM
   logic                     tbl_wr_en;
   logic [ADDR_W-1:0]        tbl_wr_addr;
   logic [ADDR_W-1:0]        tbl_rd_addr;
   logic [2*W-1:0]           tbl_rd_data;
   logic signed [W-1:0]      rd_x;
   logic signed [W-1:0]      rd_y;

   // arithmetic unit
   logic                     mdu_start;
   logic [M-1:0]             mdu_mag;
   logic [M-1:0]             mdu_quo;
   mdu_status_type           mdu_status;

   logic                     req_xfer;
   logic [NW-1:0]            n_eff;
   logic [NW-1:0]            cmp_next;
   logic                     search_last;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign tbl_wr_en   = req_xfer && (req_action == ACTION_WRITE)
                        && (int'(req_point_index) < MAX_POINTS);
   assign tbl_wr_addr = ADDR_W'(req_point_index);
   assign tbl_rd_addr = (state_ff == ST_SEARCH) ? cmp_ff + ADDR_W'(1) : '0;

   pli_ram #(
      .WIDTH (2 * W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data ({req_point_y, req_point_x}),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign rd_x = tbl_rd_data[W-1:0];
   assign rd_y = tbl_rd_data[2*W-1:W];

   assign mdu_start = (state_ff == ST_START);
   assign mdu_mag   = dy_ff[M-1] ? (~dy_ff + M'(1)) : dy_ff;

   pli_muldiv #(
      .OP_WIDTH (M)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (mdu_start),
      .mag      (mdu_mag),
      .mplr     (dxq_ff),
      .den      (den_ff),
      .quotient (mdu_quo),
      .status   (mdu_status)
   );

   // clamp the entry count into 1..MAX_POINTS
   always_comb begin
      if (csr_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(csr_ff) > MAX_POINTS) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(csr_ff);
      end
   end

   assign cmp_next    = {1'b0, cmp_ff} + NW'(1);
   assign search_last = (cmp_next == n_ff);

   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_ff;
      q_in          = q_ff;
      n_in          = n_ff;
      cmp_in        = cmp_ff;
      lo_x_in       = lo_x_ff;
      lo_y_in       = lo_y_ff;
      hi_x_in       = hi_x_ff;
      hi_y_in       = hi_y_ff;
      dy_in         = dy_ff;
      dxq_in        = dxq_ff;
      den_in        = den_ff;
      res_in        = res_ff;
      region_in     = region_ff;
      seg_in        = seg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_region_in = rsp_region_ff;
      rsp_seg_in    = rsp_seg_ff;

      if (csr_wr_en) begin
         csr_in = csr_wr_data;
      end

      // drop the result once its transfer completes
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_action == ACTION_QUERY)) begin
               q_in     = req_query_x;
               n_in     = n_eff;
               cmp_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!(q_ff > rd_x)) begin
               seg_in = cmp_ff;
               if (cmp_ff == '0) begin
                  res_in    = rd_y;
                  region_in = REGION_FIRST;
                  state_in  = ST_DELIVER;
               end else begin
                  hi_x_in   = rd_x;
                  hi_y_in   = rd_y;
                  region_in = REGION_INTERP;
                  state_in  = ST_SETUP;
               end
            end else if (search_last) begin
               seg_in    = cmp_ff;
               res_in    = rd_y;
               region_in = REGION_LAST;
               state_in  = ST_DELIVER;
            end else begin
               // advance, keeping this entry as the lower neighbour
               lo_x_in = rd_x;
               lo_y_in = rd_y;
               cmp_in  = cmp_ff + ADDR_W'(1);
            end
         end
         ST_SETUP: begin
            dy_in    = {hi_y_ff[W-1], hi_y_ff} - {lo_y_ff[W-1], lo_y_ff};
            dxq_in   = {q_ff[W-1], q_ff} - {lo_x_ff[W-1], lo_x_ff};
            den_in   = {hi_x_ff[W-1], hi_x_ff} - {lo_x_ff[W-1], lo_x_ff};
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mdu_status.done) begin
               res_in   = dy_ff[M-1] ? lo_y_ff - mdu_quo[W-1:0]
                                     : lo_y_ff + mdu_quo[W-1:0];
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_y_in      = res_ff;
               rsp_region_in = region_ff;
               rsp_seg_in    = INDEX_WIDTH'({{INDEX_WIDTH{1'b0}}, seg_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      n_ff          <= n_in;
      cmp_ff        <= cmp_in;
      lo_x_ff       <= lo_x_in;
      lo_y_ff       <= lo_y_in;
      hi_x_ff       <= hi_x_in;
      hi_y_ff       <= hi_y_in;
      dy_ff         <= dy_in;
      dxq_ff        <= dxq_in;
      den_ff        <= den_in;
      res_ff        <= res_in;
      region_ff     <= region_in;
      seg_ff        <= seg_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_region_ff <= rsp_region_in;
      rsp_seg_ff    <= rsp_seg_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_y      = rsp_y_ff;
   assign rsp_region        = rsp_region_ff;
   assign rsp_segment_index = rsp_seg_ff;

`ifndef SYNTH
   a_rsp_from_deliver : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("response raised outside delivery");

   a_start_when_free : assert property (@(posedge clock) disable iff (reset)
      mdu_start |-> !mdu_status.busy)
      else $error("arithmetic unit started while busy");

   a_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      mdu_status.done |-> (state_ff == ST_WAIT))
      else $error("arithmetic result arrived outside wait state");

   a_search_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ({1'b0, cmp_ff} < n_ff))
      else $error("search index beyond entries in use");
`endif

endmodule : piecewise_linear_interpolator_unit

`default_nettype wire
